@@ rtl/core/setc_pkg.sv @@
// Package for the sensor event timer controller.
// Holds the event codes, register indexes, reset values and shared structs.
// No dependencies.
package setc_pkg;

	localparam int unsigned CountW = 16;
	localparam int unsigned AddrW  = 5;
	localparam int unsigned DataW  = 32;
	localparam int unsigned RegIdxW = 3;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_PRESENCE = 2'd1,
		ACT_RAIN     = 2'd2,
		ACT_LIGHT    = 2'd3
	} action_t;

	typedef enum logic [RegIdxW-1:0] {
		REG_BUZZER_TICKS    = 3'd0,
		REG_DEBOUNCE_TICKS  = 3'd1,
		REG_CLIMATE_PERIOD  = 3'd2,
		REG_LIGHT_PERIOD    = 3'd3,
		REG_LIGHT_THRESHOLD = 3'd4
	} reg_idx_t;

	localparam logic [CountW-1:0] RstBuzzerTicks    = 16'd1000;
	localparam logic [CountW-1:0] RstDebounceTicks  = 16'd200;
	localparam logic [CountW-1:0] RstClimatePeriod  = 16'd2000;
	localparam logic [CountW-1:0] RstLightPeriod    = 16'd1000;
	localparam logic [CountW-1:0] RstLightThreshold = 16'd40;

	typedef struct packed {
		logic [CountW-1:0] buzzer_ticks;
		logic [CountW-1:0] debounce_ticks;
		logic [CountW-1:0] climate_period;
		logic [CountW-1:0] light_period;
		logic [CountW-1:0] light_threshold;
	} cfg_t;

	typedef struct packed {
		action_t           action;
		logic              presence_level;
		logic              rain_level;
		logic [CountW-1:0] light_level;
	} item_t;

	typedef struct packed {
		logic buzzer_on;
		logic lamps_on;
		logic raining;
		logic climate_due;
		logic light_due;
		logic rain_changed;
	} result_t;

endpackage

@@ rtl/core/setc_cfg_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on setc_pkg for register indexes, reset values and cfg_t.
module setc_cfg_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [setc_pkg::AddrW-1:0] paddr,
	input  logic [setc_pkg::DataW-1:0] pwdata,
	output logic [setc_pkg::DataW-1:0] prdata,
	output logic                    pready,
	output setc_pkg::cfg_t          cfg
);
	import setc_pkg::*;

	cfg_t                cfg_q;
	logic [RegIdxW-1:0]  idx;
	logic                wr_en;
	logic [CountW-1:0]   wval;
	logic [CountW-1:0]   rval;

	assign idx    = paddr[AddrW-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign wval   = pwdata[CountW-1:0];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buzzer_ticks    <= RstBuzzerTicks;
			cfg_q.debounce_ticks  <= RstDebounceTicks;
			cfg_q.climate_period  <= RstClimatePeriod;
			cfg_q.light_period    <= RstLightPeriod;
			cfg_q.light_threshold <= RstLightThreshold;
		end else if (wr_en) begin
			unique case (idx)
				REG_BUZZER_TICKS:    cfg_q.buzzer_ticks    <= wval;
				REG_DEBOUNCE_TICKS:  cfg_q.debounce_ticks  <= wval;
				REG_CLIMATE_PERIOD:  cfg_q.climate_period  <= wval;
				REG_LIGHT_PERIOD:    cfg_q.light_period    <= wval;
				REG_LIGHT_THRESHOLD: cfg_q.light_threshold <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BUZZER_TICKS:    rval = cfg_q.buzzer_ticks;
			REG_DEBOUNCE_TICKS:  rval = cfg_q.debounce_ticks;
			REG_CLIMATE_PERIOD:  rval = cfg_q.climate_period;
			REG_LIGHT_PERIOD:    rval = cfg_q.light_period;
			REG_LIGHT_THRESHOLD: rval = cfg_q.light_threshold;
			default:             rval = '0;
		endcase
	end

	assign prdata = {{(DataW-CountW){1'b0}}, rval};

endmodule

@@ rtl/core/setc_event_core.sv @@
// Event state: dividers, buzzer one-shot, rain debounce and lamp state.
// Computes the result of one event and updates the state when enabled.
// Depends on setc_pkg for cfg_t, item_t, result_t and the event codes.
module setc_event_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  setc_pkg::cfg_t    cfg,
	input  setc_pkg::item_t   item,
	output setc_pkg::result_t result
);
	import setc_pkg::*;

	logic [CountW-1:0] climate_cnt_q, light_cnt_q, buzzer_cnt_q, debounce_cnt_q;
	logic              buzzer_act_q, debounce_pend_q, rain_q, lamp_q;

	logic [CountW-1:0] climate_cnt_d, light_cnt_d, buzzer_cnt_d, debounce_cnt_d;
	logic              buzzer_act_d, debounce_pend_d, rain_d, lamp_d;
	logic [CountW-1:0] climate_inc, light_inc, buzzer_inc, debounce_inc;
	logic              climate_due, light_due, rain_changed;

	assign climate_inc  = climate_cnt_q + 1'b1;
	assign light_inc    = light_cnt_q + 1'b1;
	assign buzzer_inc   = buzzer_cnt_q + 1'b1;
	assign debounce_inc = debounce_cnt_q + 1'b1;

	always_comb begin
		climate_cnt_d   = climate_cnt_q;
		light_cnt_d     = light_cnt_q;
		buzzer_cnt_d    = buzzer_cnt_q;
		debounce_cnt_d  = debounce_cnt_q;
		buzzer_act_d    = buzzer_act_q;
		debounce_pend_d = debounce_pend_q;
		rain_d          = rain_q;
		lamp_d          = lamp_q;
		climate_due     = 1'b0;
		light_due       = 1'b0;
		rain_changed    = 1'b0;
		unique case (item.action)
			ACT_TICK: begin
				if (climate_inc >= cfg.climate_period) begin
					climate_due   = 1'b1;
					climate_cnt_d = '0;
				end else begin
					climate_cnt_d = climate_inc;
				end
				if (light_inc >= cfg.light_period) begin
					light_due   = 1'b1;
					light_cnt_d = '0;
				end else begin
					light_cnt_d = light_inc;
				end
				if (buzzer_act_q) begin
					buzzer_cnt_d = buzzer_inc;
					if (buzzer_inc >= cfg.buzzer_ticks) begin
						buzzer_act_d = 1'b0;
					end
				end
				if (debounce_pend_q) begin
					debounce_cnt_d = debounce_inc;
					if (debounce_inc >= cfg.debounce_ticks) begin
						debounce_pend_d = 1'b0;
						if (!item.rain_level != rain_q) begin
							rain_d       = !item.rain_level;
							rain_changed = 1'b1;
						end
					end
				end
			end
			ACT_PRESENCE: begin
				if (item.presence_level) begin
					buzzer_act_d = 1'b1;
					buzzer_cnt_d = '0;
				end
			end
			ACT_RAIN: begin
				debounce_pend_d = 1'b1;
				debounce_cnt_d  = '0;
			end
			ACT_LIGHT: begin
				lamp_d = item.light_level < cfg.light_threshold;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			climate_cnt_q   <= '0;
			light_cnt_q     <= '0;
			buzzer_cnt_q    <= '0;
			debounce_cnt_q  <= '0;
			buzzer_act_q    <= 1'b0;
			debounce_pend_q <= 1'b0;
			rain_q          <= 1'b0;
			lamp_q          <= 1'b0;
		end else if (en) begin
			climate_cnt_q   <= climate_cnt_d;
			light_cnt_q     <= light_cnt_d;
			buzzer_cnt_q    <= buzzer_cnt_d;
			debounce_cnt_q  <= debounce_cnt_d;
			buzzer_act_q    <= buzzer_act_d;
			debounce_pend_q <= debounce_pend_d;
			rain_q          <= rain_d;
			lamp_q          <= lamp_d;
		end
	end

	assign result.buzzer_on    = buzzer_act_d;
	assign result.lamps_on     = lamp_d;
	assign result.raining      = rain_d;
	assign result.climate_due  = climate_due;
	assign result.light_due    = light_due;
	assign result.rain_changed = rain_changed;

endmodule

@@ rtl/core/sensor_event_timer_controller.sv @@
// Sensor event timer controller top level.
// Input channel: one event per transfer (action, presence_level, rain_level,
// light_level) under in_valid and in_ready. Output channel: one result per
// event (buzzer_on, lamps_on, raining, climate_due, light_due, rain_changed)
// under out_valid and out_ready. Registers are written through the APB-style
// port at byte address 4*i; pready is always high.
// An event is taken into an input register, its result is computed by one
// short pass through the event core and held in the result register. One
// event is taken every cycle while the output side keeps up, set by the
// single state update in the event core.
// When the receiver stalls, the result register and the input register hold
// and in_ready drops only once both are full; no transfer is lost.
// Reset clears all counters and flags, the buzzer and lamps are off, the rain
// state is not raining, and the registers take their default values.
// Depends on setc_pkg, setc_cfg_regs and setc_event_core.
module sensor_event_timer_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic                       presence_level,
	input  logic                       rain_level,
	input  logic [setc_pkg::CountW-1:0] light_level,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       buzzer_on,
	output logic                       lamps_on,
	output logic                       raining,
	output logic                       climate_due,
	output logic                       light_due,
	output logic                       rain_changed,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [setc_pkg::AddrW-1:0] paddr,
	input  logic [setc_pkg::DataW-1:0] pwdata,
	output logic [setc_pkg::DataW-1:0] prdata,
	output logic                       pready
);
	import setc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;

	setc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv      = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.action         <= action_t'(action);
			item_s1.presence_level <= presence_level;
			item_s1.rain_level     <= rain_level;
			item_s1.light_level    <= light_level;
		end
	end

	setc_event_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cfg    (cfg),
		.item   (item_s1),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid    = valid_s2;
	assign buzzer_on    = res_s2.buzzer_on;
	assign lamps_on     = res_s2.lamps_on;
	assign raining      = res_s2.raining;
	assign climate_due  = res_s2.climate_due;
	assign light_due    = res_s2.light_due;
	assign rain_changed = res_s2.rain_changed;

endmodule

@@ tb/tb_sensor_event_timer_controller.sv @@
// Self-checking testbench for the sensor event timer controller.
// Streams tick, presence, rain and light events over valid/ready and checks each result
// against an in-bench event predictor. Depends on setc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_sensor_event_timer_controller;
	import setc_pkg::*;

	localparam int unsigned WatchdogLimit = 3000;
	localparam int unsigned LongStall     = 300;
	localparam int unsigned PhaseEvents   = 216;
	localparam logic [RegIdxW-1:0] FirstUnmapped = 3'd5;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	logic presence_level;
	logic rain_level;
	logic [CountW-1:0] light_level;
	logic out_valid;
	logic out_ready;
	logic buzzer_on;
	logic lamps_on;
	logic raining;
	logic climate_due;
	logic light_due;
	logic rain_changed;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic pready;

	sensor_event_timer_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.presence_level(presence_level),
		.rain_level(rain_level),
		.light_level(light_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.buzzer_on(buzzer_on),
		.lamps_on(lamps_on),
		.raining(raining),
		.climate_due(climate_due),
		.light_due(light_due),
		.rain_changed(rain_changed),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	item_t   pending_events[$];
	result_t expected_results[$];

	cfg_t cfg_shadow;
	logic [CountW-1:0] climate_cnt, light_cnt, buzz_cnt, debounce_cnt;
	logic buzz_active, debounce_armed, rain_latched, lamp_latched;
	logic rain_pin_now;

	int n_queued;
	int n_sent;
	int n_checked;
	int n_mismatch;
	int n_configs;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_reqs;
	int stall_seen;
	int stall_left;
	int quiet_cycles;
	logic in_done;

	function automatic result_t predict_event(item_t ev);
		result_t r;
		r = '0;
		case (ev.action)
			ACT_TICK: begin
				climate_cnt = climate_cnt + 1'b1;
				if (climate_cnt >= cfg_shadow.climate_period) begin
					r.climate_due = 1'b1;
					climate_cnt = '0;
				end
				light_cnt = light_cnt + 1'b1;
				if (light_cnt >= cfg_shadow.light_period) begin
					r.light_due = 1'b1;
					light_cnt = '0;
				end
				if (buzz_active) begin
					buzz_cnt = buzz_cnt + 1'b1;
					if (buzz_cnt >= cfg_shadow.buzzer_ticks)
						buzz_active = 1'b0;
				end
				if (debounce_armed) begin
					debounce_cnt = debounce_cnt + 1'b1;
					if (debounce_cnt >= cfg_shadow.debounce_ticks) begin
						if (!ev.rain_level != rain_latched) begin
							rain_latched = !ev.rain_level;
							r.rain_changed = 1'b1;
						end
						debounce_armed = 1'b0;
					end
				end
			end
			ACT_PRESENCE: begin
				if (ev.presence_level) begin
					buzz_active = 1'b1;
					buzz_cnt = '0;
				end
			end
			ACT_RAIN: begin
				debounce_armed = 1'b1;
				debounce_cnt = '0;
			end
			default: lamp_latched = ev.light_level < cfg_shadow.light_threshold;
		endcase
		r.buzzer_on = buzz_active;
		r.lamps_on  = lamp_latched;
		r.raining   = rain_latched;
		return r;
	endfunction

	function automatic item_t make_event(action_t a, logic p, logic r, logic [CountW-1:0] lux);
		item_t ev;
		ev.action = a;
		ev.presence_level = p;
		ev.rain_level = r;
		ev.light_level = lux;
		return ev;
	endfunction

	// Rain pin mostly follows its last change so that debounce samples see a steady level.
	function automatic item_t random_event();
		int unsigned pick;
		item_t ev;
		pick = $urandom_range(99);
		ev = make_event(ACT_TICK, 1'($urandom_range(1)), rain_pin_now, CountW'($urandom()));
		if ($urandom_range(9) == 0)
			ev.rain_level = !rain_pin_now;
		if (pick >= 55 && pick < 70) begin
			ev.action = ACT_PRESENCE;
			ev.presence_level = ($urandom_range(3) != 0);
		end else if (pick >= 70 && pick < 85) begin
			ev.action = ACT_RAIN;
			rain_pin_now = 1'($urandom_range(1));
			ev.rain_level = rain_pin_now;
		end else if (pick >= 85) begin
			ev.action = ACT_LIGHT;
			if ($urandom_range(1))
				ev.light_level = cfg_shadow.light_threshold + CountW'($urandom_range(4)) - 16'd2;
		end
		return ev;
	endfunction

	task automatic queue_event(item_t ev);
		pending_events.push_back(ev);
		n_queued++;
	endtask

	task automatic write_reg(logic [RegIdxW-1:0] idx, logic [DataW-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_BUZZER_TICKS:    cfg_shadow.buzzer_ticks = data[CountW-1:0];
			REG_DEBOUNCE_TICKS:  cfg_shadow.debounce_ticks = data[CountW-1:0];
			REG_CLIMATE_PERIOD:  cfg_shadow.climate_period = data[CountW-1:0];
			REG_LIGHT_PERIOD:    cfg_shadow.light_period = data[CountW-1:0];
			REG_LIGHT_THRESHOLD: cfg_shadow.light_threshold = data[CountW-1:0];
			default: ;
		endcase
	endtask

	task automatic load_config(logic [CountW-1:0] buzz, logic [CountW-1:0] deb,
			logic [CountW-1:0] clim, logic [CountW-1:0] lper, logic [CountW-1:0] thr);
		write_reg(REG_BUZZER_TICKS, {16'd0, buzz});
		write_reg(REG_DEBOUNCE_TICKS, {16'd0, deb});
		write_reg(REG_CLIMATE_PERIOD, {16'd0, clim});
		write_reg(REG_LIGHT_PERIOD, {16'd0, lper});
		write_reg(REG_LIGHT_THRESHOLD, {16'd0, thr});
		n_configs++;
	endtask

	task automatic drain();
		while (n_checked < n_queued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_random(int count);
		int i;
		@(posedge clk);
		for (i = 0; i < count; i++)
			queue_event(random_event());
		drain();
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		if (!in_valid || in_done) begin
			if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				action <= pending_events[0].action;
				presence_level <= pending_events[0].presence_level;
				rain_level <= pending_events[0].rain_level;
				light_level <= pending_events[0].light_level;
				void'(pending_events.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_results.push_back(predict_event(make_event(action_t'(action),
				presence_level, rain_level, light_level)));
			n_sent++;
		end
		in_done <= in_valid && in_ready;
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_seen != stall_reqs) begin
			stall_seen <= stall_reqs;
			stall_left <= LongStall;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (out_valid && out_ready) begin
			got = '{buzzer_on, lamps_on, raining, climate_due, light_due, rain_changed};
			n_checked++;
			if (expected_results.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("Unexpected result transfer: got %06b", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("Result %0d mismatch (buzz lamp rain clim light chg): exp %06b got %06b",
							n_checked, want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		presence_level = 1'b0;
		rain_level = 1'b1;
		light_level = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_done = 1'b0;
		cfg_shadow = '{RstBuzzerTicks, RstDebounceTicks, RstClimatePeriod, RstLightPeriod,
			RstLightThreshold};
		climate_cnt = '0;
		light_cnt = '0;
		buzz_cnt = '0;
		debounce_cnt = '0;
		buzz_active = 1'b0;
		debounce_armed = 1'b0;
		rain_latched = 1'b0;
		lamp_latched = 1'b0;
		rain_pin_now = 1'b1;
		n_queued = 0;
		n_sent = 0;
		n_checked = 0;
		n_mismatch = 0;
		n_configs = 0;
		stall_reqs = 0;
		stall_seen = 0;
		stall_left = 0;
		quiet_cycles = 0;
		send_idle_pct = 10;
		recv_idle_pct = 72;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: threshold edges, ignored presence, buzzer retrigger and timeout, debounce.
		load_config(16'd3, 16'd2, 16'd1, 16'd5, 16'd100);
		@(posedge clk);
		queue_event(make_event(ACT_LIGHT, 1'b0, 1'b1, 16'd0));
		queue_event(make_event(ACT_LIGHT, 1'b1, 1'b0, 16'hFFFF));
		queue_event(make_event(ACT_LIGHT, 1'b0, 1'b1, 16'd99));
		queue_event(make_event(ACT_LIGHT, 1'b0, 1'b1, 16'd100));
		queue_event(make_event(ACT_PRESENCE, 1'b0, 1'b1, 16'd0));
		queue_event(make_event(ACT_PRESENCE, 1'b1, 1'b1, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b1, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b1, 16'd0));
		queue_event(make_event(ACT_PRESENCE, 1'b1, 1'b1, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b1, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b1, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b1, 16'd0));
		queue_event(make_event(ACT_RAIN, 1'b0, 1'b0, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b0, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b0, 16'd0));
		queue_event(make_event(ACT_RAIN, 1'b0, 1'b1, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b1, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b1, 1'b1, 16'hFFFF));
		queue_event(make_event(ACT_RAIN, 1'b0, 1'b0, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b0, 16'd0));
		queue_event(make_event(ACT_RAIN, 1'b0, 1'b0, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b0, 16'd0));
		queue_event(make_event(ACT_TICK, 1'b0, 1'b0, 16'd0));
		drain();
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		@(posedge clk);
		repeat (3) queue_event(make_event(ACT_TICK, 1'b0, 1'b1, 16'd0));
		drain();
		// Periods lowered below the running counts fire on the next tick.
		write_reg(REG_CLIMATE_PERIOD, 32'd1);
		write_reg(REG_LIGHT_PERIOD, 32'd1);
		@(posedge clk);
		queue_event(make_event(ACT_TICK, 1'b0, 1'b1, 16'd0));
		drain();

		load_config(16'd5, 16'd3, 16'd7, 16'd4, 16'd1000);
		run_random(PhaseEvents);
		load_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
		write_reg(FirstUnmapped, $urandom());
		run_random(PhaseEvents);
		load_config(CountW'($urandom_range(30, 1)), CountW'($urandom_range(30, 1)),
			CountW'($urandom_range(30, 1)), CountW'($urandom_range(30, 1)),
			CountW'($urandom_range(65535)));
		run_random(PhaseEvents);

		send_idle_pct = 72;
		recv_idle_pct = 10;
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(PhaseEvents);
		load_config(CountW'($urandom_range(64, 1)), CountW'($urandom_range(64, 1)),
			CountW'($urandom_range(64, 1)), CountW'($urandom_range(64, 1)),
			CountW'($urandom_range(65535)));
		run_random(PhaseEvents);
		load_config(16'd2, 16'hFFFF, 16'hFFFF, 16'd1, 16'd32768);
		run_random(PhaseEvents);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_config(CountW'($urandom_range(16, 1)), CountW'($urandom_range(16, 1)),
			CountW'($urandom_range(16, 1)), CountW'($urandom_range(16, 1)),
			CountW'($urandom_range(65535)));
		stall_reqs++;
		run_random(PhaseEvents);
		load_config(RstBuzzerTicks, RstDebounceTicks, RstClimatePeriod, RstLightPeriod,
			RstLightThreshold);
		run_random(PhaseEvents);
		load_config(CountW'($urandom_range(200, 1)), CountW'($urandom_range(200, 1)),
			CountW'($urandom_range(200, 1)), CountW'($urandom_range(200, 1)),
			CountW'($urandom_range(65535)));
		run_random(PhaseEvents);

		repeat (10) @(negedge clk);
		if (expected_results.size() != 0) begin
			$display("%0d expected results never arrived", expected_results.size());
			n_mismatch += expected_results.size();
		end
		$display("Sent %0d events under %0d register settings with three idling patterns,",
			n_sent, n_configs);
		$display("checked %0d results, %0d failures", n_checked, n_mismatch);
		if (n_mismatch == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ sensor_event_timer_controller.f @@
rtl/core/setc_pkg.sv
rtl/core/setc_cfg_regs.sv
rtl/core/setc_event_core.sv
rtl/core/sensor_event_timer_controller.sv
tb/tb_sensor_event_timer_controller.sv
